FILE: src/dcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  localparam int unsigned IN_W      = 32;
  localparam int unsigned RATIO_W   = 27;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic signed [IN_W-1:0] value;
    logic                   is_last;
  } dcr_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_q16;
    logic [COUNT_W-1:0] distinct_count;
    logic [COUNT_W-1:0] item_count;
    logic               overflow;
  } dcr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FIN,
    ST_DIV
  } dcr_state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic count;
    logic append;
    logic set_ovf;
    logic div_start;
    logic emit;
  } dcr_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic full;
    logic ovf;
    logic last;
    logic div_done;
  } dcr_status_t;

endpackage

`default_nettype wire

FILE: src/dcr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dcr_div #(
  parameter int unsigned DW = 27,
  parameter int unsigned VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [VW:0]   shifted;
  logic          ge;

  assign shifted = {rem_q[VW-1:0], quo_q[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d = ge ? (shifted - {1'b0, dvs_q}) : shifted;
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: src/dcr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: value store, counters, scan pointer, divider, result register.
module dcr_dp #(
  parameter int unsigned MAX_ITEMS  = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dcr_pkg::dcr_in_t      in_i,
  input  wire dcr_pkg::dcr_cmd_t     cmd_i,
  output dcr_pkg::dcr_status_t       status_o,
  output logic                       valid_o,
  output dcr_pkg::dcr_out_t          result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW    = $clog2(MAX_ITEMS);
  localparam int unsigned DW    = CNT_W + dcr_pkg::FRAC_BITS;
  localparam int unsigned EXT_W = (VALUE_BITS > dcr_pkg::IN_W) ? VALUE_BITS : dcr_pkg::IN_W;
  localparam int unsigned QW    = (DW > dcr_pkg::RATIO_W) ? DW : dcr_pkg::RATIO_W;
  localparam int unsigned SW    = (CNT_W > dcr_pkg::COUNT_W) ? CNT_W : dcr_pkg::COUNT_W;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];

  logic signed [EXT_W-1:0] v_ext;
  logic [VALUE_BITS-1:0]   val_q, rdata_q;
  logic                    last_q;
  logic [CNT_W-1:0]        items_q, dist_q, idx_q;
  logic                    ovf_q, rd_vld_q, vld_q;
  dcr_pkg::dcr_out_t       res_q, res_d;
  logic                    rd_go;
  logic                    div_done;
  logic [DW-1:0]           quot;
  logic [QW-1:0]           q_ext;
  logic [SW-1:0]           items_ext, dist_ext;

  assign v_ext = EXT_W'(in_i.value);
  assign rd_go = cmd_i.scan && (idx_q != dist_q);

  dcr_div #(
    .DW (DW),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({items_q, {dcr_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (dist_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Store and read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[dist_q[AW-1:0]] <= val_q;
    end
    if (rd_go) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
    if (cmd_i.load) begin
      val_q  <= v_ext[VALUE_BITS-1:0];
      last_q <= in_i.is_last;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    q_ext     = QW'(quot);
    items_ext = SW'(items_q);
    dist_ext  = SW'(dist_q);
    if (dist_q == '0) begin
      res_d.ratio_q16 = '0;
    end else if (q_ext > QW'(dcr_pkg::RATIO_MAX)) begin
      res_d.ratio_q16 = dcr_pkg::RATIO_MAX;
    end else begin
      res_d.ratio_q16 = q_ext[dcr_pkg::RATIO_W-1:0];
    end
    res_d.distinct_count = (dist_ext > SW'(dcr_pkg::COUNT_MAX)) ? dcr_pkg::COUNT_MAX
                                                                 : dist_ext[dcr_pkg::COUNT_W-1:0];
    res_d.item_count     = (items_ext > SW'(dcr_pkg::COUNT_MAX)) ? dcr_pkg::COUNT_MAX
                                                                  : items_ext[dcr_pkg::COUNT_W-1:0];
    res_d.overflow       = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q  <= '0;
      dist_q   <= '0;
      ovf_q    <= 1'b0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      vld_q <= cmd_i.emit;
      if (cmd_i.scan_start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= rd_go;
        if (rd_go) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        items_q <= '0;
        dist_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (cmd_i.count) begin
          items_q <= items_q + 1'b1;
        end
        if (cmd_i.append) begin
          dist_q <= dist_q + 1'b1;
        end
        if (cmd_i.set_ovf) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    status_o.hit      = rd_vld_q && (rdata_q == val_q);
    status_o.scan_end = (idx_q == dist_q) && !rd_vld_q;
    status_o.full     = items_q >= CNT_W'(MAX_ITEMS);
    status_o.ovf      = ovf_q;
    status_o.last     = last_q;
    status_o.div_done = div_done;
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_dist_le_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= items_q)
    else $error("distinct count above item count");

  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= CNT_W'(MAX_ITEMS))
    else $error("item count above limit");

  a_append_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !status_o.hit && (dist_q < CNT_W'(MAX_ITEMS)))
    else $error("append on a matching value or a full store");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> !vld_q)
    else $error("result strobe held longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: src/dcr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for one item: check limit, scan store, count, divide on last.
module dcr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire dcr_pkg::dcr_status_t status_i,
  output dcr_pkg::dcr_cmd_t         cmd_o,
  output logic                      busy_o
);

  dcr_pkg::dcr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      dcr_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = dcr_pkg::ST_CHECK;
        end
      end
      dcr_pkg::ST_CHECK: begin
        if (status_i.ovf) begin
          state_d = dcr_pkg::ST_FIN;
        end else if (status_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = dcr_pkg::ST_FIN;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = dcr_pkg::ST_SCAN;
        end
      end
      dcr_pkg::ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.count = 1'b1;
          state_d     = dcr_pkg::ST_FIN;
        end else if (status_i.scan_end) begin
          cmd_o.count  = 1'b1;
          cmd_o.append = 1'b1;
          state_d      = dcr_pkg::ST_FIN;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      dcr_pkg::ST_FIN: begin
        if (status_i.last) begin
          cmd_o.div_start = 1'b1;
          state_d         = dcr_pkg::ST_DIV;
        end else begin
          state_d = dcr_pkg::ST_IDLE;
        end
      end
      dcr_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.emit = 1'b1;
          state_d    = dcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == dcr_pkg::ST_DIV) && status_i.div_done)
    else $error("result emitted outside the divide state");

  a_div_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> status_i.last)
    else $error("divide started on an item that does not end the set");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == dcr_pkg::ST_IDLE))
    else $error("controller not idle after result");
`endif

endmodule

`default_nettype wire

FILE: src/distinct_count_ratio_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Distinct-value counter with dedupe ratio.
// Input channel: drive in_i and raise start_i; the item transfers at the
// clock edge where start_i is high and busy_o is low. Set in_i.is_last on
// the final value of a set.
// Result channel: on the final value one result appears on result_o for a
// single cycle with valid_o high; the receiver cannot stall it, so capture
// it in that cycle. Fields: ratio_q16 = floor(items * 2^16 / distinct),
// both counts saturated to 11 bits, and overflow when the set ran past
// MAX_ITEMS values (later values are dropped, counts hold).
// Timing: an item holds busy_o while the distinct values stored so far are
// scanned; the store is one memory read port scanned one entry per cycle,
// so a match ends the scan early. A value seen after overflow skips the
// scan. The final item adds a restoring division, one quotient bit per
// cycle; once the divider is done the result is registered and strobes
// the cycle after that, with busy_o already low.
// Reset clears the counters and the store fill count at once; no sweep is
// needed, since only entries below the fill count are compared. The store
// likewise empties after each result.
module distinct_count_ratio_core #(
  parameter int unsigned MAX_ITEMS  = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire dcr_pkg::dcr_in_t  in_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output dcr_pkg::dcr_out_t      result_o
);

  dcr_pkg::dcr_cmd_t    cmd;
  dcr_pkg::dcr_status_t status;

  // Sequence each item through check, scan and count; divide on last.
  dcr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold the store, counters and divider; register the result.
  dcr_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_ITEMS    = 1024;
  localparam int unsigned HALF_PERIOD  = 6;
  // The longest quiet stretch in a correct run is one full store scan
  // plus the divide; allow many times that.
  localparam int unsigned QUIET_LIMIT  = 20000;
  // Give stray results time to show after the divide and the strobe.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned SET_LEN_MAX  = 40;

  localparam bit [dcr_pkg::IN_W-1:0] VAL_MIN  = {1'b1, {(dcr_pkg::IN_W-1){1'b0}}};
  localparam bit [dcr_pkg::IN_W-1:0] VAL_MAX  = {1'b0, {(dcr_pkg::IN_W-1){1'b1}}};
  localparam bit [dcr_pkg::IN_W-1:0] VAL_NEG1 = {dcr_pkg::IN_W{1'b1}};

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start_i = 1'b0;
  dcr_pkg::dcr_in_t  in_i    = '0;
  logic              busy_o;
  logic              valid_o;
  dcr_pkg::dcr_out_t result_o;

  distinct_count_ratio_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(dcr_pkg::IN_W)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Elements waiting to be driven, and the set summaries the block owes us.
  dcr_pkg::dcr_in_t  element_q[$];
  dcr_pkg::dcr_out_t summary_q[$];

  // Running tally of the set in progress, kept alongside the block.
  bit [dcr_pkg::IN_W-1:0] stored_values[$];
  int unsigned            set_items;
  int unsigned            set_distinct;
  bit                     set_overflowed;

  int unsigned sender_idle_pct = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;

  // Fold one transferred element into the tally; on the final element of a
  // set, queue the summary the block should produce and clear the tally.
  function automatic void tally_element(input dcr_pkg::dcr_in_t item);
    bit [dcr_pkg::IN_W-1:0] key;
    bit                     hit;
    logic [63:0]            ratio;
    dcr_pkg::dcr_out_t      summary;
    key = item.value;
    hit = 1'b0;
    if (!set_overflowed) begin
      if (set_items < MAX_ITEMS) begin
        set_items++;
        foreach (stored_values[k]) begin
          if (stored_values[k] == key) hit = 1'b1;
        end
        if (!hit && set_distinct < MAX_ITEMS) begin
          stored_values.push_back(key);
          set_distinct++;
        end
      end else begin
        // Past the size limit: drop the element, freeze the counts.
        set_overflowed = 1'b1;
      end
    end
    if (item.is_last) begin
      ratio = '0;
      if (set_distinct != 0) begin
        ratio = (64'(set_items) << dcr_pkg::FRAC_BITS) / set_distinct;
      end
      summary.ratio_q16      = (ratio > dcr_pkg::RATIO_MAX) ? dcr_pkg::RATIO_MAX
                                                            : ratio[dcr_pkg::RATIO_W-1:0];
      summary.distinct_count = (set_distinct > dcr_pkg::COUNT_MAX)
                               ? dcr_pkg::COUNT_MAX : set_distinct[dcr_pkg::COUNT_W-1:0];
      summary.item_count     = (set_items > dcr_pkg::COUNT_MAX)
                               ? dcr_pkg::COUNT_MAX : set_items[dcr_pkg::COUNT_W-1:0];
      summary.overflow       = set_overflowed;
      summary_q.push_back(summary);
      stored_values.delete();
      set_items      = 0;
      set_distinct   = 0;
      set_overflowed = 1'b0;
    end
  endfunction

  function automatic void push_element(input bit [dcr_pkg::IN_W-1:0] value, input bit last);
    dcr_pkg::dcr_in_t item;
    item.value   = value;
    item.is_last = last;
    element_q.push_back(item);
  endfunction

  // Build one set from a small pool so that repeats are common. The pool mixes
  // fully random words, single-bit neighbors of one base word (to catch a
  // comparator that ignores a bit), the base word itself and the corner words.
  task automatic queue_random_set(input int unsigned len, input int unsigned pool_size);
    bit [dcr_pkg::IN_W-1:0] pool[$];
    bit [dcr_pkg::IN_W-1:0] base;
    bit [1:0]               corner;
    base = $urandom();
    for (int i = 0; i < pool_size; i++) begin
      corner = $urandom_range(3);
      case ($urandom_range(3))
        0: pool.push_back($urandom());
        1: pool.push_back(base ^ (1 << $urandom_range(dcr_pkg::IN_W - 1)));
        2: pool.push_back({corner[1], {(dcr_pkg::IN_W-1){corner[0]}}});
        default: pool.push_back(base);
      endcase
    end
    for (int i = 0; i < len; i++) begin
      push_element(pool[$urandom_range(pool.size() - 1)], i == len - 1);
    end
  endtask

  // Hold the sender until the queue is empty, every summary has come back,
  // and the divider has had time to settle. Sample on the falling edge so
  // the driver's updates of this cycle are already visible.
  task automatic drain_sets();
    while (element_q.size() != 0 || start_i) @(negedge clk_i);
    while (summary_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Driver: a transfer happens at an edge with start_i high and busy_o low.
  // Hold start_i and the item steady while the block is busy; once the
  // transfer lands (or when idle), decide on the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      in_i    <= '0;
    end else begin
      if (start_i && !busy_o) begin
        tally_element(in_i);
      end
      if (!start_i || !busy_o) begin
        if (element_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start_i <= 1'b1;
          in_i    <= element_q.pop_front();
        end else begin
          // Drop start_i and put noise on the bus; the block must ignore it.
          start_i <= 1'b0;
          in_i    <= dcr_pkg::dcr_in_t'({$urandom(), 1'($urandom())});
        end
      end
    end
  end

  // Monitor: the result is valid for one cycle only, so take it at the edge
  // that ends that cycle and compare it against the oldest owed summary.
  // The watchdog counts edges with neither an input transfer nor a result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (summary_q.size() == 0) begin
          $error("result with no summary owed: ratio_q16 %0d distinct %0d items %0d",
                 result_o.ratio_q16, result_o.distinct_count, result_o.item_count);
          error_count++;
        end else begin
          if (result_o.ratio_q16 !== summary_q[0].ratio_q16) begin
            $error("ratio_q16: expected %0d, got %0d", summary_q[0].ratio_q16,
                   result_o.ratio_q16);
            error_count++;
          end
          if (result_o.distinct_count !== summary_q[0].distinct_count) begin
            $error("distinct_count: expected %0d, got %0d", summary_q[0].distinct_count,
                   result_o.distinct_count);
            error_count++;
          end
          if (result_o.item_count !== summary_q[0].item_count) begin
            $error("item_count: expected %0d, got %0d", summary_q[0].item_count,
                   result_o.item_count);
            error_count++;
          end
          if (result_o.overflow !== summary_q[0].overflow) begin
            $error("overflow: expected %0d, got %0d", summary_q[0].overflow,
                   result_o.overflow);
            error_count++;
          end
          void'(summary_q.pop_front());
        end
      end
      if (valid_o || (start_i && !busy_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sets, no idling.
    // A set of one element: ratio exactly 1.0.
    push_element(VAL_MIN, 1'b1);
    // Corner words with repeats: 8 items, 4 distinct, ratio 2.0.
    push_element(VAL_MAX, 1'b0);
    push_element(VAL_MIN, 1'b0);
    push_element(VAL_MAX, 1'b0);
    push_element('0, 1'b0);
    push_element(VAL_NEG1, 1'b0);
    push_element('0, 1'b0);
    push_element(VAL_MIN, 1'b0);
    push_element(VAL_NEG1, 1'b1);
    // Words that differ only in the sign bit must stay apart.
    push_element(32'h0000_0001, 1'b0);
    push_element(32'h8000_0001, 1'b0);
    push_element(32'h0000_0001, 1'b0);
    push_element(32'hFFFF_FFFE, 1'b0);
    push_element(32'h7FFF_FFFE, 1'b1);
    // Fractional ratio 2.5, alternating bit patterns.
    push_element(32'h5555_5555, 1'b0);
    push_element(32'h5555_5555, 1'b0);
    push_element(32'h5555_5555, 1'b0);
    push_element(32'h5555_5555, 1'b0);
    push_element(32'hAAAA_AAAA, 1'b1);
    // 7 items over 3 values: the ratio truncates.
    push_element(32'd10, 1'b0);
    push_element(32'd20, 1'b0);
    push_element(32'd30, 1'b0);
    push_element(32'd10, 1'b0);
    push_element(32'd20, 1'b0);
    push_element(32'd30, 1'b0);
    push_element(32'd10, 1'b1);
    drain_sets();

    // Random phases with different sender idling; drain between phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       sender_idle_pct = 87;
        2:       sender_idle_pct = 24;
        default: sender_idle_pct = 0;
      endcase

      if (phase == 0) begin
        // Fill the store with exactly MAX_ITEMS distinct words, then run
        // three fresh words past the limit, the last one closing the set.
        // The low bits carry the index, which keeps the words distinct; the
        // ends are the signed extremes. Words past the limit are not counted.
        for (int i = 0; i < MAX_ITEMS + 3; i++) begin
          if (i == 0) begin
            push_element(VAL_MIN, 1'b0);
          end else if (i == MAX_ITEMS - 1) begin
            push_element(VAL_MAX, 1'b0);
          end else if (i >= MAX_ITEMS) begin
            push_element($urandom(), i == MAX_ITEMS + 2);
          end else begin
            push_element(($urandom() & ~32'h3FF) | i, 1'b0);
          end
        end
      end

      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          len = $urandom_range(SET_LEN_MAX, 13);
        end else begin
          len = $urandom_range(12, 1);
        end
        queue_random_set(len, $urandom_range(len, 1));
        queued += len;
      end

      drain_sets();
    end

    if (error_count == 0 && summary_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dcr_pkg.sv
src/dcr_div.sv
src/dcr_dp.sv
src/dcr_ctrl.sv
src/distinct_count_ratio_core.sv
tb/tb.sv
